// ===== rtl/keyed_deadline_timer_table_assert.svh =====
// Assertion macros used by the timer table checker.
`ifndef KEYED_DEADLINE_TIMER_TABLE_ASSERT_SVH
`define KEYED_DEADLINE_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define KDTT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define KDTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kdtt_pkg.sv =====
// Shared types and constants for the keyed deadline timer table.
`timescale 1ns / 1ps
`default_nettype none

package kdtt_pkg;

    localparam int ACT_W       = 3;
    localparam int KEY_W       = 16;
    localparam int DELAY_W     = 32;
    localparam int TAG_W       = 32;
    localparam int STAT_W      = 2;
    localparam int PEND_W      = 5;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);
    localparam int FIDX_W      = $clog2(MAX_RESULTS);

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK     = 3'd0,
        ACT_SCHEDULE = 3'd1,
        ACT_CANCEL   = 3'd2,
        ACT_LOOKUP   = 3'd3,
        ACT_POLL     = 3'd4,
        ACT_CLEAR    = 3'd5
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_EMIT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic apply;
        logic emit;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/keyed_deadline_timer_table.sv =====
// Top level of the keyed deadline timer table.
//
// A table of up to DEPTH keyed one-shot deadlines on a saturating tick clock.
// Requests arrive on the s_ stream: s_tuser carries the action (tick,
// schedule, cancel, lookup, poll, clear) and s_tdata the key, delay and tag.
// Results leave on the m_ stream; m_tlast marks the final result of a
// request and m_tuser flags a result that carries an expired key.
// Tick, clear and unused action codes take no search: the request is taken,
// applied in the apply state and its single result is then registered in
// the emit state, once the output register is free.
// Schedule, cancel, lookup and poll walk the slot memories one slot per
// cycle through a registered read port before the apply and emit states;
// the next request is taken in the cycle after the last result is loaded,
// and a poll that fires entries gives one result for each of them.
// A new request is taken as soon as the last result of the previous one sits
// in the output register, even while the receiver has not yet taken it.
// When m_tready is low while a result is shown, the output register holds and the block waits.
// After reset the table is empty, the clock reads zero and no result is shown.
`timescale 1ns / 1ps
`default_nettype none

module keyed_deadline_timer_table
#(
    parameter int DEPTH     = 16,
    parameter int KEY_BITS  = 16,
    parameter int TIME_BITS = 48
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // key[15:0], delay[47:16], tag[79:48]
    input  wire logic [2:0]  s_tuser,   // action[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // status[1:0], found[2], is_due[3], tag_match[4],
                                        // stored_tag[36:5], fired_key[52:37],
                                        // pending[57:53], zero[63:58]
    output logic             m_tuser,   // fired_valid
    output logic             m_tlast    // last
);

    kdtt_pkg::cmd_t cmd;
    kdtt_pkg::sts_t sts;

    logic [kdtt_pkg::STAT_W-1:0]      status;
    logic                             found;
    logic                             is_due;
    logic                             tag_match;
    logic signed [kdtt_pkg::TAG_W-1:0] stored_tag;
    logic [kdtt_pkg::KEY_W-1:0]       fired_key;
    logic [kdtt_pkg::PEND_W-1:0]      pending;

    kdtt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

    kdtt_dp
    #(
        .DEPTH     (DEPTH),
        .KEY_BITS  (KEY_BITS),
        .TIME_BITS (TIME_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_action   (s_tuser),
        .in_key      (s_tdata[15:0]),
        .in_delay    (s_tdata[47:16]),
        .in_tag      (s_tdata[79:48]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .status      (status),
        .found       (found),
        .is_due      (is_due),
        .tag_match   (tag_match),
        .stored_tag  (stored_tag),
        .fired_key   (fired_key),
        .fired_valid (m_tuser),
        .last        (m_tlast),
        .pending     (pending)
    );

    // Pack the result fields, lowest field first, padded to whole bytes.
    assign m_tdata = {6'd0, pending, fired_key, stored_tag, tag_match, is_due, found, status};

endmodule

`default_nettype wire

// ===== rtl/kdtt_ctrl.sv =====
// Sequencing state machine of the keyed deadline timer table.
`timescale 1ns / 1ps
`default_nettype none

module kdtt_ctrl
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [kdtt_pkg::ACT_W-1:0]     in_action,
    output kdtt_pkg::cmd_t                      cmd,
    input  wire kdtt_pkg::sts_t                 sts
);

    kdtt_pkg::state_t state_reg;
    kdtt_pkg::state_t state_next;
    logic             needs_scan;

    // Actions that must search the table before they can act.
    assign needs_scan = (in_action == kdtt_pkg::ACT_SCHEDULE) ||
                        (in_action == kdtt_pkg::ACT_CANCEL)   ||
                        (in_action == kdtt_pkg::ACT_LOOKUP)   ||
                        (in_action == kdtt_pkg::ACT_POLL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kdtt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kdtt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = needs_scan ? kdtt_pkg::S_SCAN : kdtt_pkg::S_APPLY;
                end
            end
            kdtt_pkg::S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = kdtt_pkg::S_APPLY;
                end
            end
            kdtt_pkg::S_APPLY:
            begin
                state_next = kdtt_pkg::S_EMIT;
            end
            kdtt_pkg::S_EMIT:
            begin
                if (sts.out_free && sts.emit_last)
                begin
                    state_next = kdtt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kdtt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd       = '0;
        case (state_reg)
            kdtt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            kdtt_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            kdtt_pkg::S_APPLY:
            begin
                cmd.apply = 1'b1;
            end
            kdtt_pkg::S_EMIT:
            begin
                cmd.emit = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/kdtt_dp.sv =====
// Datapath of the keyed deadline timer table: slot memories, scan pipe and result register.
`timescale 1ns / 1ps
`default_nettype none

module kdtt_dp
#(
    parameter int DEPTH     = 16,
    parameter int KEY_BITS  = 16,
    parameter int TIME_BITS = 48
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire kdtt_pkg::cmd_t                    cmd,
    output kdtt_pkg::sts_t                         sts,
    input  wire logic [kdtt_pkg::ACT_W-1:0]        in_action,
    input  wire logic [kdtt_pkg::KEY_W-1:0]        in_key,
    input  wire logic signed [kdtt_pkg::DELAY_W-1:0] in_delay,
    input  wire logic signed [kdtt_pkg::TAG_W-1:0]   in_tag,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [kdtt_pkg::STAT_W-1:0]            status,
    output logic                                   found,
    output logic                                   is_due,
    output logic                                   tag_match,
    output logic signed [kdtt_pkg::TAG_W-1:0]      stored_tag,
    output logic [kdtt_pkg::KEY_W-1:0]             fired_key,
    output logic                                   fired_valid,
    output logic                                   last,
    output logic [kdtt_pkg::PEND_W-1:0]            pending
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (KEY_BITS < kdtt_pkg::KEY_W) ? KEY_BITS : kdtt_pkg::KEY_W;
    localparam int SW = ((TIME_BITS > kdtt_pkg::DELAY_W) ? TIME_BITS : kdtt_pkg::DELAY_W) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [AW:0]          SCAN_END = (AW + 1)'(DEPTH);
    localparam logic [kdtt_pkg::FIRE_W-1:0] FIRE_MAX =
        kdtt_pkg::FIRE_W'(kdtt_pkg::MAX_RESULTS);

    // Slot memories.
    logic [KW-1:0]             mem_key [DEPTH];
    logic [TIME_BITS-1:0]      mem_dl  [DEPTH];
    logic [kdtt_pkg::TAG_W-1:0] mem_tag [DEPTH];

    // Table state.
    logic [DEPTH-1:0]          valid_reg;
    logic [TIME_BITS-1:0]      clock_reg;
    logic [CW-1:0]             count_reg;

    // Captured request.
    logic [kdtt_pkg::ACT_W-1:0] act_reg;
    logic [KW-1:0]              key_reg;
    logic [kdtt_pkg::TAG_W-1:0] tag_reg;
    logic [TIME_BITS-1:0]       due_reg;
    logic [TIME_BITS-1:0]       due_next;

    // Scan pipe.
    logic [AW:0]                addr_reg;
    logic                       rd_vld_reg;
    logic [AW-1:0]              rd_idx_reg;
    logic [KW-1:0]              rd_key_reg;
    logic [TIME_BITS-1:0]       rd_dl_reg;
    logic [kdtt_pkg::TAG_W-1:0] rd_tag_reg;

    // Scan findings.
    logic                       match_vld_reg;
    logic [AW-1:0]              match_idx_reg;
    logic [kdtt_pkg::TAG_W-1:0] match_tag_reg;
    logic                       match_due_reg;
    logic                       free_vld_reg;
    logic [AW-1:0]              free_idx_reg;
    logic [kdtt_pkg::KEY_W-1:0] fbuf_reg [kdtt_pkg::MAX_RESULTS];
    logic [kdtt_pkg::FIRE_W-1:0] fcnt_reg;

    // Result sequencing.
    kdtt_pkg::status_t          st_reg;
    logic [kdtt_pkg::FIRE_W-1:0] eidx_reg;

    // Output register.
    logic                        out_valid_reg;
    logic [kdtt_pkg::STAT_W-1:0] status_reg;
    logic                        found_reg;
    logic                        is_due_reg;
    logic                        tag_match_reg;
    logic [kdtt_pkg::TAG_W-1:0]  stored_tag_reg;
    logic [kdtt_pkg::KEY_W-1:0]  fired_key_reg;
    logic                        fired_valid_reg;
    logic                        last_reg;
    logic [kdtt_pkg::PEND_W-1:0] pending_reg;

    logic [kdtt_pkg::DELAY_W-1:0] delay_nn;
    logic [SW-1:0]               due_sum;
    logic                        rd_en;
    logic                        rd_live;
    logic                        rd_slot_valid;
    logic                        hit;
    logic                        fire;
    logic                        free_hit;
    logic                        is_sched;
    logic                        mem_we;
    logic                        mem_wkey;
    logic [AW-1:0]               wr_idx;
    logic                        lookup_hit;
    logic                        poll_fired;
    logic                        emit_last;
    logic                        out_free;
    logic                        load_out;

    // Deadline: a negative delay counts as zero, and the sum saturates.
    assign delay_nn = in_delay[kdtt_pkg::DELAY_W-1] ? '0 : in_delay;
    assign due_sum  = SW'(clock_reg) + SW'(delay_nn);
    assign due_next = (due_sum > SW'(TIME_MAX)) ? TIME_MAX : due_sum[TIME_BITS-1:0];

    assign rd_en         = cmd.scan && (addr_reg < SCAN_END);
    assign rd_live       = cmd.scan && rd_vld_reg;
    assign rd_slot_valid = valid_reg[rd_idx_reg];
    assign hit           = rd_live && rd_slot_valid && (rd_key_reg == key_reg);
    assign free_hit      = rd_live && !rd_slot_valid && !free_vld_reg;
    assign fire          = rd_live && (act_reg == kdtt_pkg::ACT_POLL) && rd_slot_valid &&
                           (clock_reg >= rd_dl_reg) && (fcnt_reg < FIRE_MAX);

    assign is_sched = cmd.apply && (act_reg == kdtt_pkg::ACT_SCHEDULE);
    assign mem_we   = is_sched && (match_vld_reg || free_vld_reg);
    assign mem_wkey = is_sched && !match_vld_reg && free_vld_reg;
    assign wr_idx   = match_vld_reg ? match_idx_reg : free_idx_reg;

    assign lookup_hit = (act_reg == kdtt_pkg::ACT_LOOKUP) && match_vld_reg;
    assign poll_fired = (act_reg == kdtt_pkg::ACT_POLL) && (fcnt_reg != '0);
    assign emit_last  = !poll_fired ||
                        ((eidx_reg + kdtt_pkg::FIRE_W'(1)) == fcnt_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign load_out   = cmd.emit && out_free;

    assign sts.scan_done = cmd.scan && (addr_reg == SCAN_END);
    assign sts.emit_last = emit_last;
    assign sts.out_free  = out_free;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_dl[wr_idx]  <= due_reg;
            mem_tag[wr_idx] <= tag_reg;
        end
        if (mem_wkey)
        begin
            mem_key[wr_idx] <= key_reg;
        end
        if (rd_en)
        begin
            rd_key_reg <= mem_key[addr_reg[AW-1:0]];
            rd_dl_reg  <= mem_dl[addr_reg[AW-1:0]];
            rd_tag_reg <= mem_tag[addr_reg[AW-1:0]];
            rd_idx_reg <= addr_reg[AW-1:0];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= in_action;
            key_reg <= in_key[KW-1:0];
            tag_reg <= in_tag;
            due_reg <= due_next;
        end
        if (hit && !match_vld_reg)
        begin
            match_idx_reg <= rd_idx_reg;
            match_tag_reg <= rd_tag_reg;
            match_due_reg <= (clock_reg >= rd_dl_reg);
        end
        if (free_hit)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (fire)
        begin
            fbuf_reg[fcnt_reg[kdtt_pkg::FIDX_W-1:0]] <= kdtt_pkg::KEY_W'(rd_key_reg);
        end
        if (load_out)
        begin
            status_reg      <= st_reg;
            found_reg       <= lookup_hit;
            is_due_reg      <= lookup_hit && match_due_reg;
            tag_match_reg   <= lookup_hit && (match_tag_reg == tag_reg);
            stored_tag_reg  <= lookup_hit ? match_tag_reg : '0;
            fired_key_reg   <= poll_fired ? fbuf_reg[eidx_reg[kdtt_pkg::FIDX_W-1:0]] : '0;
            fired_valid_reg <= poll_fired;
            last_reg        <= emit_last;
            pending_reg     <= kdtt_pkg::PEND_W'(count_reg);
        end
    end

    // Control and table state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            clock_reg     <= '0;
            count_reg     <= '0;
            addr_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            match_vld_reg <= 1'b0;
            free_vld_reg  <= 1'b0;
            fcnt_reg      <= '0;
            st_reg        <= kdtt_pkg::STAT_OK;
            eidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                addr_reg      <= '0;
                match_vld_reg <= 1'b0;
                free_vld_reg  <= 1'b0;
                fcnt_reg      <= '0;
                st_reg        <= kdtt_pkg::STAT_OK;
                eidx_reg      <= '0;
            end

            if (rd_en)
            begin
                addr_reg <= addr_reg + (AW + 1)'(1);
            end
            rd_vld_reg <= rd_en;

            if (hit)
            begin
                match_vld_reg <= 1'b1;
            end
            if (free_hit)
            begin
                free_vld_reg <= 1'b1;
            end
            if (fire)
            begin
                valid_reg[rd_idx_reg] <= 1'b0;
                count_reg             <= count_reg - CW'(1);
                fcnt_reg              <= fcnt_reg + kdtt_pkg::FIRE_W'(1);
            end

            if (cmd.apply)
            begin
                case (act_reg)
                    kdtt_pkg::ACT_TICK:
                    begin
                        if (clock_reg != TIME_MAX)
                        begin
                            clock_reg <= clock_reg + TIME_BITS'(1);
                        end
                    end
                    kdtt_pkg::ACT_SCHEDULE:
                    begin
                        if (!match_vld_reg)
                        begin
                            if (free_vld_reg)
                            begin
                                valid_reg[free_idx_reg] <= 1'b1;
                                count_reg               <= count_reg + CW'(1);
                            end
                            else
                            begin
                                st_reg <= kdtt_pkg::STAT_FULL;
                            end
                        end
                    end
                    kdtt_pkg::ACT_CANCEL:
                    begin
                        if (match_vld_reg)
                        begin
                            valid_reg[match_idx_reg] <= 1'b0;
                            count_reg                <= count_reg - CW'(1);
                        end
                        else
                        begin
                            st_reg <= kdtt_pkg::STAT_NOT_FOUND;
                        end
                    end
                    kdtt_pkg::ACT_LOOKUP:
                    begin
                        if (!match_vld_reg)
                        begin
                            st_reg <= kdtt_pkg::STAT_NOT_FOUND;
                        end
                    end
                    kdtt_pkg::ACT_CLEAR:
                    begin
                        valid_reg <= '0;
                        count_reg <= '0;
                    end
                    default:
                    begin
                        st_reg <= kdtt_pkg::STAT_OK;
                    end
                endcase
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                eidx_reg      <= eidx_reg + kdtt_pkg::FIRE_W'(1);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign is_due      = is_due_reg;
    assign tag_match   = tag_match_reg;
    assign stored_tag  = stored_tag_reg;
    assign fired_key   = fired_key_reg;
    assign fired_valid = fired_valid_reg;
    assign last        = last_reg;
    assign pending     = pending_reg;

endmodule

`default_nettype wire

// ===== rtl/kdtt_checker.sv =====
// Port-level checker for the keyed deadline timer table and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_deadline_timer_table_assert.svh"

module kdtt_checker
#(
    parameter int DEPTH = 16
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // A stalled result stays put.
    `KDTT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // A fired key comes with status ok and no lookup fields.
    `KDTT_ASSERT_IMP(a_fire_plain, m_tvalid && m_tuser, m_tdata[36:0] == 37'd0, "fired result carries lookup data")

    // Without a found entry the lookup fields read zero.
    `KDTT_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tdata[2], m_tdata[36:3] == 34'd0, "lookup fields set without a found entry")

    // The pending count never exceeds the table size.
    `KDTT_ASSERT_IMP(a_pend_bound, m_tvalid, (DEPTH >= 32) || (m_tdata[57:53] <= DEPTH), "pending count above table size")

    // While a run of results is still open no new request is taken.
    `KDTT_ASSERT_IMP(a_run_busy, m_tvalid && !m_tlast, !s_tready, "request taken inside an open result run")

endmodule

bind keyed_deadline_timer_table kdtt_checker
#(
    .DEPTH (DEPTH)
)
u_kdtt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== bench/tb_keyed_deadline_timer_table.sv =====
// Self-checking stream testbench for the keyed deadline timer table.
`timescale 1ns / 1ps

module tb_keyed_deadline_timer_table;

    localparam int TABLE_DEPTH     = 16;
    localparam int CLOCK_BITS      = 48;
    localparam int RANDOM_REQUESTS = 355;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 150;
    localparam int MAX_REPORTS     = 10;
    localparam int POOL_SIZE       = 8;

    localparam logic [CLOCK_BITS-1:0] CLOCK_MAX = '1;

    // The action field is three bits wide, but only six codes are defined.
    // The two spare codes must leave the table alone and answer with one reply.
    localparam logic [kdtt_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [kdtt_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [kdtt_pkg::ACT_W-1:0]   action;
        logic [kdtt_pkg::KEY_W-1:0]   key;
        logic [kdtt_pkg::DELAY_W-1:0] delay;
        logic [kdtt_pkg::TAG_W-1:0]   tag;
    } timer_req_t;

    typedef struct packed {
        kdtt_pkg::status_t           status;
        logic                        found;
        logic                        is_due;
        logic                        tag_match;
        logic [kdtt_pkg::TAG_W-1:0]  stored_tag;
        logic [kdtt_pkg::KEY_W-1:0]  fired_key;
        logic                        fired_valid;
        logic                        last;
        logic [kdtt_pkg::PEND_W-1:0] pending;
    } timer_reply_t;

    // One line of the directed table. When typed is set, the reply written
    // into the row is what the block must answer; otherwise the predictor decides.
    typedef struct packed {
        timer_req_t   req;
        logic         typed;
        timer_reply_t reply;
    } table_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;     // key[15:0], delay[47:16], tag[79:48]
    logic [2:0]  s_tuser  = '0;     // action[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // status[1:0], found[2], is_due[3], tag_match[4],
                                    // stored_tag[36:5], fired_key[52:37], pending[57:53]
    logic        m_tuser;           // fired_valid
    logic        m_tlast;           // last

    always #5 clk = ~clk;

    keyed_deadline_timer_table
    #(
        .DEPTH     (TABLE_DEPTH),
        .KEY_BITS  (kdtt_pkg::KEY_W),
        .TIME_BITS (CLOCK_BITS)
    )
    dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the timer table, advanced once per accepted request.
    logic                       slot_live [TABLE_DEPTH];
    logic [kdtt_pkg::KEY_W-1:0] slot_id   [TABLE_DEPTH];
    logic [CLOCK_BITS-1:0]      slot_due  [TABLE_DEPTH];
    logic [kdtt_pkg::TAG_W-1:0] slot_gen  [TABLE_DEPTH];
    logic [CLOCK_BITS-1:0]      now_ms;
    int                         live_count;

    // Replies still owed by the block, oldest first.
    timer_reply_t reply_queue [$];

    int   mismatch_count = 0;
    int   replies_seen   = 0;
    int   random_sent    = 0;
    logic sender_quiet   = 1'b0;

    logic [kdtt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    function automatic int slot_of(logic [kdtt_pkg::KEY_W-1:0] key);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot_live[i] && slot_id[i] == key)
                return i;
        return -1;
    endfunction

    // Applies one request to the shadow table and queues the replies it owes.
    function automatic void timer_table_step(timer_req_t req);
        timer_reply_t          base;
        timer_reply_t          batch [$];
        logic [CLOCK_BITS-1:0] wait_ms;
        logic [CLOCK_BITS-1:0] due;
        int                    s;

        base = '0;
        case (req.action)
            kdtt_pkg::ACT_TICK:
            begin
                // The clock sticks at its top value instead of wrapping.
                if (now_ms != CLOCK_MAX)
                    now_ms++;
            end
            kdtt_pkg::ACT_SCHEDULE:
            begin
                // A negative delay counts as zero; the deadline saturates.
                wait_ms = '0;
                if (!req.delay[kdtt_pkg::DELAY_W-1])
                    wait_ms[kdtt_pkg::DELAY_W-1:0] = req.delay;
                due = (wait_ms > CLOCK_MAX - now_ms) ? CLOCK_MAX : now_ms + wait_ms;
                s = slot_of(req.key);
                if (s < 0)
                begin
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                        if (!slot_live[i])
                            s = i;
                    if (s >= 0)
                    begin
                        slot_live[s] = 1'b1;
                        slot_id[s]   = req.key;
                        live_count++;
                    end
                end
                if (s < 0)
                    base.status = kdtt_pkg::STAT_FULL;
                else
                begin
                    slot_due[s] = due;
                    slot_gen[s] = req.tag;
                end
            end
            kdtt_pkg::ACT_CANCEL:
            begin
                s = slot_of(req.key);
                if (s < 0)
                    base.status = kdtt_pkg::STAT_NOT_FOUND;
                else
                begin
                    slot_live[s] = 1'b0;
                    live_count--;
                end
            end
            kdtt_pkg::ACT_LOOKUP:
            begin
                s = slot_of(req.key);
                if (s < 0)
                    base.status = kdtt_pkg::STAT_NOT_FOUND;
                else
                begin
                    base.found      = 1'b1;
                    base.is_due     = (now_ms >= slot_due[s]);
                    base.tag_match  = (slot_gen[s] == req.tag);
                    base.stored_tag = slot_gen[s];
                end
            end
            kdtt_pkg::ACT_POLL:
            begin
                // Due entries leave in slot order, at most one reply each.
                for (int i = 0; i < TABLE_DEPTH && batch.size() < kdtt_pkg::MAX_RESULTS; i++)
                begin
                    if (slot_live[i] && now_ms >= slot_due[i])
                    begin
                        base.fired_key   = slot_id[i];
                        base.fired_valid = 1'b1;
                        batch.push_back(base);
                        slot_live[i] = 1'b0;
                        live_count--;
                    end
                end
            end
            kdtt_pkg::ACT_CLEAR:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    slot_live[i] = 1'b0;
                live_count = 0;
            end
            default:
            begin
            end
        endcase

        // Every request but a poll that fires answers with a single reply; an
        // empty poll answers with one blank reply.
        if (batch.size() == 0)
            batch.push_back(base);
        foreach (batch[k])
        begin
            batch[k].last    = (k == batch.size() - 1);
            batch[k].pending = live_count[kdtt_pkg::PEND_W-1:0];
            reply_queue.push_back(batch[k]);
        end
    endfunction

    function automatic table_row_t plain_row(logic [kdtt_pkg::ACT_W-1:0] action,
                                             logic [kdtt_pkg::KEY_W-1:0] key,
                                             logic [kdtt_pkg::DELAY_W-1:0] delay,
                                             logic [kdtt_pkg::TAG_W-1:0] tag);
        table_row_t row;

        row            = '0;
        row.req.action = action;
        row.req.key    = key;
        row.req.delay  = delay;
        row.req.tag    = tag;
        return row;
    endfunction

    function automatic table_row_t known_row(logic [kdtt_pkg::ACT_W-1:0] action,
                                             logic [kdtt_pkg::KEY_W-1:0] key,
                                             logic [kdtt_pkg::DELAY_W-1:0] delay,
                                             logic [kdtt_pkg::TAG_W-1:0] tag,
                                             kdtt_pkg::status_t status,
                                             logic found, logic is_due, logic tag_match,
                                             logic [kdtt_pkg::TAG_W-1:0] stored_tag,
                                             logic [kdtt_pkg::PEND_W-1:0] pending);
        table_row_t row;

        row                  = plain_row(action, key, delay, tag);
        row.typed            = 1'b1;
        row.reply.status     = status;
        row.reply.found      = found;
        row.reply.is_due     = is_due;
        row.reply.tag_match  = tag_match;
        row.reply.stored_tag = stored_tag;
        row.reply.last       = 1'b1;
        row.reply.pending    = pending;
        return row;
    endfunction

    // Presents one request after a random gap and returns at the edge where
    // it is taken. Valid stays high when the next request follows at once.
    task automatic offer(timer_req_t req);
        int gap;

        if ($urandom_range(0, 31) == 0)
            sender_quiet = !sender_quiet;
        gap = sender_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {req.tag, req.delay, req.key};
        s_tuser  <= req.action;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic issue(timer_req_t req);
        offer(req);
        timer_table_step(req);
        random_sent++;
    endtask

    // Stops offering and waits until every owed reply has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (reply_queue.size() != 0);
    endtask

    function automatic logic [kdtt_pkg::KEY_W-1:0] pick_key();
        logic [31:0] r;

        r = $urandom;
        if ($urandom_range(0, 9) == 0)
            return r[kdtt_pkg::KEY_W-1:0];
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Mostly short delays so that ticks make entries due, with negative and
    // full-range values mixed in.
    function automatic logic [kdtt_pkg::DELAY_W-1:0] pick_delay();
        logic [31:0] r;

        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1:    return {1'b1, r[30:0]};
            2, 3:    return r;
            default: return $urandom_range(0, 8);
        endcase
    endfunction

    function automatic timer_req_t workload_request();
        timer_req_t req;
        int         roll;
        int         s;

        req.key   = pick_key();
        req.delay = pick_delay();
        req.tag   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            req.action = kdtt_pkg::ACT_SCHEDULE;
        else if (roll < 60)
            req.action = kdtt_pkg::ACT_TICK;
        else if (roll < 75)
            req.action = kdtt_pkg::ACT_LOOKUP;
        else if (roll < 86)
            req.action = kdtt_pkg::ACT_CANCEL;
        else if (roll < 97)
            req.action = kdtt_pkg::ACT_POLL;
        else if (roll < 98)
            req.action = kdtt_pkg::ACT_CLEAR;
        else
            req.action = ($urandom_range(0, 1) == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;

        // Give lookups a fair chance of a matching generation.
        s = slot_of(req.key);
        if (req.action == kdtt_pkg::ACT_LOOKUP && s >= 0 && $urandom_range(0, 1) == 0)
            req.tag = slot_gen[s];
        return req;
    endfunction

    function automatic timer_req_t noise_request();
        timer_req_t  req;
        logic [31:0] r;

        r          = $urandom;
        req.action = r[kdtt_pkg::ACT_W-1:0];
        req.key    = r[31:32-kdtt_pkg::KEY_W];
        req.delay  = $urandom;
        req.tag    = $urandom;
        return req;
    endfunction

    // Clears the table, fills every slot, tries one more new key against the
    // full table, re-arms a key that is already there, then lets all entries
    // fall due so that one poll empties the whole table.
    task automatic fill_table();
        timer_req_t  req;
        logic [31:0] r;

        r = $urandom;
        req = '0;
        req.action = kdtt_pkg::ACT_CLEAR;
        issue(req);
        for (int i = 0; i <= TABLE_DEPTH + 1; i++)
        begin
            req.action = kdtt_pkg::ACT_SCHEDULE;
            req.key    = (i <= TABLE_DEPTH) ?
                         r[kdtt_pkg::KEY_W-1:0] + kdtt_pkg::KEY_W'(i) : r[kdtt_pkg::KEY_W-1:0];
            req.delay  = $urandom_range(0, 3);
            req.tag    = $urandom;
            issue(req);
        end
        req.action = kdtt_pkg::ACT_TICK;
        repeat (4) issue(req);
        req.action = kdtt_pkg::ACT_POLL;
        issue(req);
    endtask

    // Reply checker: every reply taken is held against the oldest owed one.
    always @(posedge clk)
    begin : check_reply
        timer_reply_t seen;
        timer_reply_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            seen.status      = kdtt_pkg::status_t'(m_tdata[1:0]);
            seen.found       = m_tdata[2];
            seen.is_due      = m_tdata[3];
            seen.tag_match   = m_tdata[4];
            seen.stored_tag  = m_tdata[36:5];
            seen.fired_key   = m_tdata[52:37];
            seen.pending     = m_tdata[57:53];
            seen.fired_valid = m_tuser;
            seen.last        = m_tlast;
            replies_seen++;
            if (reply_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: reply with none owed, data %h user %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = reply_queue.pop_front();
                if (seen.status != want.status || seen.found != want.found ||
                    seen.is_due != want.is_due || seen.tag_match != want.tag_match ||
                    seen.stored_tag != want.stored_tag || seen.fired_key != want.fired_key ||
                    seen.fired_valid != want.fired_valid || seen.last != want.last ||
                    seen.pending != want.pending)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: reply mismatch (status found due match tag key fired last pend)",
                                 $time);
                        $display("  expected %0d %b %b %b %h %h %b %b %0d", want.status,
                                 want.found, want.is_due, want.tag_match, want.stored_tag,
                                 want.fired_key, want.fired_valid, want.last, want.pending);
                        $display("  actual   %0d %b %b %b %h %h %b %b %0d", seen.status,
                                 seen.found, seen.is_due, seen.tag_match, seen.stored_tag,
                                 seen.fired_key, seen.fired_valid, seen.last, seen.pending);
                    end
                end
            end
        end
    end

    // Reply side: a random stall before each reply, quiet stretches without
    // stalls, and one long hold-off that backs the block up into its input.
    initial
    begin : receiver
        int   stall;
        logic quiet;
        logic held;

        quiet = 1'b0;
        held  = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                quiet = !quiet;
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (!held && replies_seen >= HOLD_OFF_AFTER)
            begin
                held  = 1'b1;
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin : stimulus
        table_row_t rows [$];
        logic       mid_drained;
        int         roll;

        mid_drained = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom_range(0, 16'hFFFF);
        for (int i = 0; i < TABLE_DEPTH; i++)
            slot_live[i] = 1'b0;
        now_ms     = '0;
        live_count = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests. Fresh out of reset the table is empty, so misses
        // and an empty poll come first; then the extremes of key, delay and tag.
        rows.push_back(known_row(kdtt_pkg::ACT_LOOKUP, 16'h0000, 32'h0000_0000, 32'h0000_0000,
                                 kdtt_pkg::STAT_NOT_FOUND, 1'b0, 1'b0, 1'b0, 32'h0, 5'd0));
        rows.push_back(known_row(kdtt_pkg::ACT_CANCEL, 16'hFFFF, 32'h0000_0000, 32'h0000_0000,
                                 kdtt_pkg::STAT_NOT_FOUND, 1'b0, 1'b0, 1'b0, 32'h0, 5'd0));
        rows.push_back(known_row(kdtt_pkg::ACT_POLL, 16'h0000, 32'h0000_0000, 32'h0000_0000,
                                 kdtt_pkg::STAT_OK, 1'b0, 1'b0, 1'b0, 32'h0, 5'd0));
        rows.push_back(known_row(kdtt_pkg::ACT_SCHEDULE, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 kdtt_pkg::STAT_OK, 1'b0, 1'b0, 1'b0, 32'h0, 5'd1));
        // The most negative delay is taken as zero.
        rows.push_back(known_row(kdtt_pkg::ACT_SCHEDULE, 16'h0000, 32'h8000_0000, 32'h8000_0000,
                                 kdtt_pkg::STAT_OK, 1'b0, 1'b0, 1'b0, 32'h0, 5'd2));
        rows.push_back(known_row(kdtt_pkg::ACT_SCHEDULE, 16'h5A5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 kdtt_pkg::STAT_OK, 1'b0, 1'b0, 1'b0, 32'h0, 5'd3));
        rows.push_back(known_row(kdtt_pkg::ACT_LOOKUP, 16'h0000, 32'h0000_0000, 32'h8000_0000,
                                 kdtt_pkg::STAT_OK, 1'b1, 1'b1, 1'b1, 32'h8000_0000, 5'd3));
        rows.push_back(known_row(kdtt_pkg::ACT_LOOKUP, 16'hFFFF, 32'h0000_0000, 32'h0000_0000,
                                 kdtt_pkg::STAT_OK, 1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, 5'd3));
        // Re-arming a key keeps its slot and takes the new deadline and tag.
        rows.push_back(plain_row(kdtt_pkg::ACT_SCHEDULE, 16'hFFFF, 32'h0000_0002,
                                 32'h0000_0005));
        rows.push_back(plain_row(kdtt_pkg::ACT_SCHEDULE, 16'hA5A5, 32'h0000_0001,
                                 32'h0000_0000));
        rows.push_back(plain_row(kdtt_pkg::ACT_TICK, 16'h0000, 32'h0000_0000, 32'h0000_0000));
        // Three entries are due now and leave in slot order.
        rows.push_back(plain_row(kdtt_pkg::ACT_POLL, 16'h0000, 32'h0000_0000, 32'h0000_0000));
        rows.push_back(plain_row(kdtt_pkg::ACT_TICK, 16'h0000, 32'h0000_0000, 32'h0000_0000));
        rows.push_back(plain_row(kdtt_pkg::ACT_LOOKUP, 16'hFFFF, 32'h0000_0000, 32'h0000_0005));
        rows.push_back(plain_row(kdtt_pkg::ACT_LOOKUP, 16'hFFFF, 32'h0000_0000, 32'h0000_0006));
        rows.push_back(plain_row(kdtt_pkg::ACT_CANCEL, 16'hFFFF, 32'h0000_0000, 32'h0000_0000));
        rows.push_back(plain_row(ACT_SPARE_LO, 16'h1234, 32'h0000_0003, 32'h0000_0003));
        rows.push_back(plain_row(kdtt_pkg::ACT_SCHEDULE, 16'h0001, 32'h0000_0000,
                                 32'h0000_0001));
        rows.push_back(plain_row(ACT_SPARE_HI, 16'h0001, 32'h0000_0000, 32'h0000_0001));
        rows.push_back(known_row(kdtt_pkg::ACT_CLEAR, 16'h0000, 32'h0000_0000, 32'h0000_0000,
                                 kdtt_pkg::STAT_OK, 1'b0, 1'b0, 1'b0, 32'h0, 5'd0));
        rows.push_back(known_row(kdtt_pkg::ACT_POLL, 16'h0000, 32'h0000_0000, 32'h0000_0000,
                                 kdtt_pkg::STAT_OK, 1'b0, 1'b0, 1'b0, 32'h0, 5'd0));
        rows.push_back(known_row(kdtt_pkg::ACT_LOOKUP, 16'h0001, 32'h0000_0000, 32'h0000_0001,
                                 kdtt_pkg::STAT_NOT_FOUND, 1'b0, 1'b0, 1'b0, 32'h0, 5'd0));

        foreach (rows[i])
        begin
            offer(rows[i].req);
            timer_table_step(rows[i].req);
            // A typed row owes exactly one reply; the typed one replaces the
            // prediction while the shadow table still follows the request.
            if (rows[i].typed)
            begin
                void'(reply_queue.pop_back());
                reply_queue.push_back(rows[i].reply);
            end
        end
        drain();

        // Random part: mostly coherent bursts on a small pool of keys, with
        // full-table sequences and a little pure noise mixed in.
        fill_table();
        while (random_sent < RANDOM_REQUESTS)
        begin
            if (!mid_drained && random_sent >= RANDOM_REQUESTS / 2)
            begin
                drain();
                mid_drained = 1'b1;
            end
            roll = $urandom_range(0, 19);
            if (roll == 0)
                fill_table();
            else if (roll < 17)
                repeat ($urandom_range(4, 12)) issue(workload_request());
            else
                repeat ($urandom_range(1, 4)) issue(noise_request());
            if ($urandom_range(0, 7) == 0)
                key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom_range(0, 16'hFFFF);
        end

        drain();
        repeat (2 * (TABLE_DEPTH + 4)) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS keyed_deadline_timer_table");
        else
            $display("FAIL keyed_deadline_timer_table");
        $finish;
    end

    // Far beyond the slowest correct run: every reply stalled to the limit,
    // every poll firing the whole table, and the long hold-off.
    initial
    begin : watchdog
        #6_000_000;
        $display("FAIL keyed_deadline_timer_table");
        $finish;
    end

endmodule
